// ===== rtl/nlrn_pkg.sv =====
// Shared constants for the nearest left/right neighbor search block.
`timescale 1ns / 1ps

package nlrn_pkg;

  // Default widths of the coordinate and id fields.
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned ID_BITS_DEF    = 16;

  // Facing components are fixed signed Q1.14 words.
  localparam int unsigned DIR_BITS  = 16;

  // Reported distances.
  localparam int unsigned DIST_BITS = 24;
  localparam logic [DIST_BITS-1:0] NONE_DIST = 24'd9999999;
  localparam logic [DIST_BITS-1:0] DIST_MAX  = 24'hFFFFFF;

endpackage

// ===== rtl/nlrn_if.sv =====
// Valid/ready channel interfaces for candidate items and search results.
`timescale 1ns / 1ps

interface nlrn_cand_if #(
  parameter int unsigned COORD_BITS = nlrn_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = nlrn_pkg::ID_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        ref_x;
  logic signed [COORD_BITS-1:0]        ref_y;
  logic signed [nlrn_pkg::DIR_BITS-1:0] dir_x;
  logic signed [nlrn_pkg::DIR_BITS-1:0] dir_y;
  logic                                same_type_check;
  logic        [ID_BITS-1:0]           self_id;
  logic        [ID_BITS-1:0]           cand_id;
  logic signed [COORD_BITS-1:0]        cand_x;
  logic signed [COORD_BITS-1:0]        cand_y;
  logic                                cand_last;

  modport source (
    output valid, ref_x, ref_y, dir_x, dir_y, same_type_check, self_id, cand_id,
           cand_x, cand_y, cand_last,
    input  ready
  );
  modport sink (
    input  valid, ref_x, ref_y, dir_x, dir_y, same_type_check, self_id, cand_id,
           cand_x, cand_y, cand_last,
    output ready
  );
endinterface

interface nlrn_res_if #(
  parameter int unsigned ID_BITS = nlrn_pkg::ID_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic                           left_found;
  logic [ID_BITS-1:0]             left_id;
  logic [nlrn_pkg::DIST_BITS-1:0] left_dist;
  logic                           right_found;
  logic [ID_BITS-1:0]             right_id;
  logic [nlrn_pkg::DIST_BITS-1:0] right_dist;

  modport source (
    output valid, left_found, left_id, left_dist,
           right_found, right_id, right_dist,
    input  ready
  );
  modport sink (
    input  valid, left_found, left_id, left_dist,
           right_found, right_id, right_dist,
    output ready
  );
endinterface

// ===== rtl/nlrn_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module nlrn_isqrt #(
  parameter int unsigned RAD_W = 2 * nlrn_pkg::COORD_BITS_DEF + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [RAD_W-1:0]         radicand_i,
  output logic                     done_o,
  output logic [(RAD_W+1)/2-1:0]   root_o
);

  localparam int unsigned STEPS = (RAD_W + 1) / 2;
  localparam int unsigned PAD_W = 2 * STEPS;
  localparam int unsigned RT_W  = STEPS;
  localparam int unsigned REM_W = RT_W + 2;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [PAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q;
  logic [RT_W-1:0]  root_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down the next pair of radicand bits and try a one digit.
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[PAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= PAD_W'(radicand_i);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q <= {rad_q[PAD_W-3:0], 2'b00};
        if (fits) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RT_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/nearest_left_right_neighbor.sv =====
// Top level of the nearest left/right neighbor search over a candidate stream.
// Candidates are taken one at a time: one is accepted only in the idle state, then goes
// through the shared multiplier steps and an update state before the next is taken. After
// the last candidate the two square roots run back to back in one shared root unit, and
// the result is registered after the right root is done, or later while an earlier result
// is still held. Reset (rst_ni, asynchronous, active low) empties both sides and the
// result register.
`timescale 1ns / 1ps

module nearest_left_right_neighbor #(
  parameter int unsigned COORD_BITS = nlrn_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = nlrn_pkg::ID_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  nlrn_cand_if.sink  cand_i,
  nlrn_res_if.source res_o
);

  // Offsets carry one bit more than the coordinates. The shared multiplier takes the
  // wider of a facing component and an offset on one side and an offset on the other.
  localparam int unsigned OFF_W  = COORD_BITS + 1;
  localparam int unsigned AW     = (nlrn_pkg::DIR_BITS > OFF_W) ? nlrn_pkg::DIR_BITS : OFF_W;
  localparam int unsigned PROD_W = AW + OFF_W;
  localparam int unsigned DOT_W  = PROD_W + 1;
  localparam int unsigned DSQ_W  = 2 * COORD_BITS + 1;
  localparam int unsigned RT_W   = (DSQ_W + 1) / 2;
  localparam int unsigned SAT_W  = (RT_W > nlrn_pkg::DIST_BITS) ? RT_W : nlrn_pkg::DIST_BITS;

  // Multiplier schedule: the product of one step is summed in the next cycle.
  localparam logic [2:0] STEP_DOT_X = 3'd0;
  localparam logic [2:0] STEP_DOT_Y = 3'd1;
  localparam logic [2:0] STEP_SQ_X  = 3'd2;
  localparam logic [2:0] STEP_SQ_Y  = 3'd3;
  localparam logic [2:0] STEP_DRAIN = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_SQ_L,
    S_SQ_R,
    S_OUT
  } state_e;

  state_e state_q;

  // Working copy of the accepted candidate.
  logic signed [OFF_W-1:0]              ox_q;
  logic signed [OFF_W-1:0]              oy_q;
  logic signed [nlrn_pkg::DIR_BITS-1:0] dir_x_q;
  logic signed [nlrn_pkg::DIR_BITS-1:0] dir_y_q;
  logic        [ID_BITS-1:0]            id_q;
  logic                                 skip_q;
  logic                                 last_q;

  logic [2:0]               step_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic [DSQ_W-1:0]         dsq_q;

  // Best candidate so far on each side.
  logic               left_seen_q;
  logic [DSQ_W-1:0]   left_dsq_q;
  logic [ID_BITS-1:0] left_id_q;
  logic               right_seen_q;
  logic [DSQ_W-1:0]   right_dsq_q;
  logic [ID_BITS-1:0] right_id_q;

  // Root unit handshake and results.
  logic             sq_start_q;
  logic [DSQ_W-1:0] sq_rad_q;
  logic             sq_done;
  logic [RT_W-1:0]  sq_root;
  logic [RT_W-1:0]  root_l_q;

  // Result register.
  logic                           res_valid_q;
  logic                           res_lf_q;
  logic [ID_BITS-1:0]             res_lid_q;
  logic [nlrn_pkg::DIST_BITS-1:0] res_ld_q;
  logic                           res_rf_q;
  logic [ID_BITS-1:0]             res_rid_q;
  logic [nlrn_pkg::DIST_BITS-1:0] res_rd_q;

  logic                     cand_xfer;
  logic signed [AW-1:0]     mul_a;
  logic signed [OFF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     on_left;
  logic                     left_upd;
  logic                     right_upd;
  logic [DSQ_W-1:0]         left_dsq_d;
  logic [nlrn_pkg::DIST_BITS-1:0] dist_l;
  logic [nlrn_pkg::DIST_BITS-1:0] dist_r;

  assign cand_i.ready = (state_q == S_IDLE);
  assign cand_xfer    = cand_i.valid && cand_i.ready;

  // Operand selection for the one shared signed multiplier.
  always_comb begin
    case (step_q)
      STEP_DOT_X: begin
        mul_a = AW'(dir_x_q);
        mul_b = ox_q;
      end
      STEP_DOT_Y: begin
        mul_a = AW'(dir_y_q);
        mul_b = oy_q;
      end
      STEP_SQ_X: begin
        mul_a = AW'(ox_q);
        mul_b = ox_q;
      end
      STEP_SQ_Y: begin
        mul_a = AW'(oy_q);
        mul_b = oy_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // A negative dot product puts the candidate on the left; zero counts as right.
  // A side takes the candidate only on a strictly smaller squared distance.
  assign on_left    = dot_q[DOT_W-1];
  assign left_upd   = !skip_q && on_left && (!left_seen_q || (dsq_q < left_dsq_q));
  assign right_upd  = !skip_q && !on_left && (!right_seen_q || (dsq_q < right_dsq_q));
  assign left_dsq_d = left_upd ? dsq_q : left_dsq_q;

  // Saturate a root to the distance field; an empty side reports the marker value.
  function automatic logic [nlrn_pkg::DIST_BITS-1:0] sat_dist(input logic seen,
                                                              input logic [RT_W-1:0] root);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(root);
    if (!seen) begin
      sat_dist = nlrn_pkg::NONE_DIST;
    end else if (wide > SAT_W'(nlrn_pkg::DIST_MAX)) begin
      sat_dist = nlrn_pkg::DIST_MAX;
    end else begin
      sat_dist = wide[nlrn_pkg::DIST_BITS-1:0];
    end
  endfunction

  assign dist_l = sat_dist(left_seen_q, root_l_q);
  assign dist_r = sat_dist(right_seen_q, sq_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ox_q         <= '0;
      oy_q         <= '0;
      dir_x_q      <= '0;
      dir_y_q      <= '0;
      id_q         <= '0;
      skip_q       <= 1'b0;
      last_q       <= 1'b0;
      step_q       <= STEP_DOT_X;
      prod_q       <= '0;
      dot_q        <= '0;
      dsq_q        <= '0;
      left_seen_q  <= 1'b0;
      left_dsq_q   <= '1;
      left_id_q    <= '0;
      right_seen_q <= 1'b0;
      right_dsq_q  <= '1;
      right_id_q   <= '0;
      sq_start_q   <= 1'b0;
      sq_rad_q     <= '0;
      root_l_q     <= '0;
      res_valid_q  <= 1'b0;
      res_lf_q     <= 1'b0;
      res_lid_q    <= '0;
      res_ld_q     <= '0;
      res_rf_q     <= 1'b0;
      res_rid_q    <= '0;
      res_rd_q     <= '0;
    end else begin
      sq_start_q <= 1'b0;
      // In S_OUT the result register is refilled in the same cycle as its transfer.
      if (res_valid_q && res_o.ready && (state_q != S_OUT)) begin
        res_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (cand_xfer) begin
            ox_q    <= OFF_W'(cand_i.cand_x) - OFF_W'(cand_i.ref_x);
            oy_q    <= OFF_W'(cand_i.cand_y) - OFF_W'(cand_i.ref_y);
            dir_x_q <= cand_i.dir_x;
            dir_y_q <= cand_i.dir_y;
            id_q    <= cand_i.cand_id;
            skip_q  <= cand_i.same_type_check && (cand_i.self_id == cand_i.cand_id);
            last_q  <= cand_i.cand_last;
            step_q  <= STEP_DOT_X;
            state_q <= S_MUL;
          end
        end

        S_MUL: begin
          prod_q <= mul_p;
          case (step_q)
            STEP_DOT_Y: dot_q <= DOT_W'(prod_q);
            STEP_SQ_X:  dot_q <= dot_q + DOT_W'(prod_q);
            STEP_SQ_Y:  dsq_q <= prod_q[DSQ_W-1:0];
            STEP_DRAIN: dsq_q <= dsq_q + prod_q[DSQ_W-1:0];
            default: ;
          endcase
          if (step_q == STEP_DRAIN) begin
            state_q <= S_UPD;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end

        S_UPD: begin
          if (left_upd) begin
            left_seen_q <= 1'b1;
            left_dsq_q  <= dsq_q;
            left_id_q   <= id_q;
          end
          if (right_upd) begin
            right_seen_q <= 1'b1;
            right_dsq_q  <= dsq_q;
            right_id_q   <= id_q;
          end
          if (last_q) begin
            sq_rad_q   <= left_dsq_d;
            sq_start_q <= 1'b1;
            state_q    <= S_SQ_L;
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_SQ_L: begin
          if (sq_done) begin
            root_l_q   <= sq_root;
            sq_rad_q   <= right_dsq_q;
            sq_start_q <= 1'b1;
            state_q    <= S_SQ_R;
          end
        end

        S_SQ_R: begin
          if (sq_done) begin
            state_q <= S_OUT;
          end
        end

        S_OUT: begin
          // The right root stays on the unit's output until the next start.
          if (!res_valid_q || res_o.ready) begin
            res_valid_q  <= 1'b1;
            res_lf_q     <= left_seen_q;
            res_lid_q    <= left_seen_q ? left_id_q : '0;
            res_ld_q     <= dist_l;
            res_rf_q     <= right_seen_q;
            res_rid_q    <= right_seen_q ? right_id_q : '0;
            res_rd_q     <= dist_r;
            left_seen_q  <= 1'b0;
            left_dsq_q   <= '1;
            left_id_q    <= '0;
            right_seen_q <= 1'b0;
            right_dsq_q  <= '1;
            right_id_q   <= '0;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  nlrn_isqrt #(
    .RAD_W (DSQ_W)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start_q),
    .radicand_i (sq_rad_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign res_o.valid       = res_valid_q;
  assign res_o.left_found  = res_lf_q;
  assign res_o.left_id     = res_lid_q;
  assign res_o.left_dist   = res_ld_q;
  assign res_o.right_found = res_rf_q;
  assign res_o.right_id    = res_rid_q;
  assign res_o.right_dist  = res_rd_q;

endmodule

// ===== verif/nlrn_side_checker.sv =====
// Scoreboard that predicts and checks the results of the nearest left/right neighbor search.
`timescale 1ns / 1ps

module nlrn_side_checker #(
  parameter int unsigned COORD_BITS = nlrn_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = nlrn_pkg::ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nlrn_cand_if        cand_i,
  nlrn_res_if         res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned DSQ_BITS     = 2 * COORD_BITS + 2;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef logic [nlrn_pkg::DIST_BITS-1:0] dist_t;

  typedef struct packed {
    logic                seen;
    logic [ID_BITS-1:0]  id;
    logic [DSQ_BITS-1:0] dsq;
  } side_best_t;

  typedef struct packed {
    logic               left_found;
    logic [ID_BITS-1:0] left_id;
    dist_t              left_dist;
    logic               right_found;
    logic [ID_BITS-1:0] right_id;
    dist_t              right_dist;
  } neighbor_report_t;

  localparam side_best_t SIDE_EMPTY = '{seen: 1'b0, id: '0, dsq: '1};

  side_best_t       left_best;
  side_best_t       right_best;
  neighbor_report_t report_q[$];
  int unsigned      wrong_reports;

  // Largest root whose square does not exceed the squared distance.
  function automatic dist_t floor_root(side_best_t side);
    longint unsigned dsq;
    longint unsigned root;
    longint unsigned trial;
    if (!side.seen) return nlrn_pkg::NONE_DIST;
    dsq  = 64'(side.dsq);
    root = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= dsq) root = trial;
    end
    if (root > 64'(nlrn_pkg::DIST_MAX)) return nlrn_pkg::DIST_MAX;
    return dist_t'(root);
  endfunction

  // Only a strictly closer candidate displaces the one already held.
  function automatic side_best_t keep_nearer(side_best_t side, logic [ID_BITS-1:0] id,
                                             logic [DSQ_BITS-1:0] dsq);
    if (side.seen && dsq >= side.dsq) return side;
    return '{seen: 1'b1, id: id, dsq: dsq};
  endfunction

  function automatic neighbor_report_t make_report(side_best_t lft, side_best_t rgt);
    neighbor_report_t rep;
    rep.left_found  = lft.seen;
    rep.left_id     = lft.seen ? lft.id : '0;
    rep.left_dist   = floor_root(lft);
    rep.right_found = rgt.seen;
    rep.right_id    = rgt.seen ? rgt.id : '0;
    rep.right_dist  = floor_root(rgt);
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    neighbor_report_t got;
    neighbor_report_t want;
    longint           ox;
    longint           oy;
    longint           dot;
    longint           dsq;
    if (!rst_ni) begin
      left_best     = SIDE_EMPTY;
      right_best    = SIDE_EMPTY;
      wrong_reports = 0;
      report_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.left_found, res_i.left_id, res_i.left_dist,
                res_i.right_found, res_i.right_id, res_i.right_dist};
        if (report_q.size() == 0) begin
          wrong_reports++;
          if (wrong_reports <= REPORT_LIMIT)
            $display("%0t: unexpected result L(%0b,%0d,%0d) R(%0b,%0d,%0d)", $realtime,
                     got.left_found, got.left_id, got.left_dist,
                     got.right_found, got.right_id, got.right_dist);
        end else begin
          want = report_q.pop_front();
          if (got.left_found !== want.left_found || got.left_id !== want.left_id ||
              got.left_dist !== want.left_dist ||
              got.right_found !== want.right_found || got.right_id !== want.right_id ||
              got.right_dist !== want.right_dist) begin
            wrong_reports++;
            if (wrong_reports <= REPORT_LIMIT) begin
              $display("%0t: expected L(%0b,%0d,%0d) R(%0b,%0d,%0d)",
                       $realtime, want.left_found, want.left_id, want.left_dist,
                       want.right_found, want.right_id, want.right_dist);
              $display("%0t:      got L(%0b,%0d,%0d) R(%0b,%0d,%0d)",
                       $realtime, got.left_found, got.left_id, got.left_dist,
                       got.right_found, got.right_id, got.right_dist);
            end
          end
        end
      end

      if (cand_i.valid && cand_i.ready) begin
        if (!(cand_i.same_type_check && cand_i.self_id == cand_i.cand_id)) begin
          ox  = longint'(cand_i.cand_x) - longint'(cand_i.ref_x);
          oy  = longint'(cand_i.cand_y) - longint'(cand_i.ref_y);
          dot = longint'(cand_i.dir_x) * ox + longint'(cand_i.dir_y) * oy;
          dsq = ox * ox + oy * oy;
          if (dot < 0) left_best = keep_nearer(left_best, cand_i.cand_id, DSQ_BITS'(dsq));
          else right_best = keep_nearer(right_best, cand_i.cand_id, DSQ_BITS'(dsq));
        end
        if (cand_i.cand_last) begin
          report_q.push_back(make_report(left_best, right_best));
          left_best  = SIDE_EMPTY;
          right_best = SIDE_EMPTY;
        end
      end

      fail_count_o <= wrong_reports;
      pending_o    <= report_q.size();
    end
  end

endmodule

// ===== verif/nearest_left_right_neighbor_tb.sv =====
// Testbench top for the nearest left/right neighbor search: stimulus, idling and verdict.
`timescale 1ns / 1ps

module nearest_left_right_neighbor_tb;

  localparam int unsigned COORD_BITS     = nlrn_pkg::COORD_BITS_DEF;
  localparam int unsigned ID_BITS        = nlrn_pkg::ID_BITS_DEF;
  localparam int unsigned DIR_BITS       = nlrn_pkg::DIR_BITS;
  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned TOTAL_ITEMS    = 1350;
  // The last stretch of items runs with no sender gaps and the result side always ready.
  localparam int unsigned CALM_ITEMS     = 150;
  localparam int unsigned HOLD_CYCLES    = 400;
  // Extra wait after the last owed result, to catch any extra result.
  localparam int unsigned DRAIN_CYCLES   = 2 * COORD_BITS + 40;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  // Unit length of a Q1.14 facing component.
  localparam int          FACING_ONE     = 16384;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIR_BITS-1:0]   facing_t;
  typedef logic        [ID_BITS-1:0]    inst_id_t;

  typedef struct {
    coord_t   ref_x;
    coord_t   ref_y;
    facing_t  dir_x;
    facing_t  dir_y;
    logic     same_type_check;
    inst_id_t self_id;
    inst_id_t cand_id;
    coord_t   cand_x;
    coord_t   cand_y;
    logic     cand_last;
  } cand_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  // When set, neither side idles any more.
  logic        calm        = 1'b0;
  // Asks the result side for one long hold-off while candidates keep coming.
  logic        hold_req    = 1'b0;
  logic        sender_gaps = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned fail_count;
  int unsigned pending;

  nlrn_cand_if #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) cand_ch ();
  nlrn_res_if  #(.ID_BITS(ID_BITS))                          res_ch ();

  nearest_left_right_neighbor #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cand_i(cand_ch),
    .res_o (res_ch)
  );

  // The scoreboard watches both channels and reports failures and results still owed.
  nlrn_side_checker #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cand_i      (cand_ch),
    .res_i       (res_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Facing components: the unit extremes, zero, and anything in between.
  function automatic facing_t pick_facing();
    case ($urandom_range(0, 5))
      0: return facing_t'(FACING_ONE);
      1: return -facing_t'(FACING_ONE);
      2: return '0;
      default: return facing_t'(int'($urandom_range(0, 2 * FACING_ONE)) - FACING_ONE);
    endcase
  endfunction

  // A coordinate near a base point; it may wrap at the edge of the coordinate range.
  function automatic coord_t nudge(coord_t base, int unsigned spread);
    return coord_t'(int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread));
  endfunction

  function automatic cand_item_t make_item(int rx, int ry, int fx, int fy, bit chk,
                                           int sid, int cid, int cx, int cy, bit last);
    cand_item_t it;
    it.ref_x           = coord_t'(rx);
    it.ref_y           = coord_t'(ry);
    it.dir_x           = facing_t'(fx);
    it.dir_y           = facing_t'(fy);
    it.same_type_check = chk;
    it.self_id         = inst_id_t'(sid);
    it.cand_id         = inst_id_t'(cid);
    it.cand_x          = coord_t'(cx);
    it.cand_y          = coord_t'(cy);
    it.cand_last       = last;
    return it;
  endfunction

  // Presents one candidate and holds it until the transfer. Valid stays high into the
  // next item unless a gap is drawn, so valid is assigned only once per clock edge.
  task automatic offer_candidate(input cand_item_t it);
    cand_ch.valid           <= 1'b1;
    cand_ch.ref_x           <= it.ref_x;
    cand_ch.ref_y           <= it.ref_y;
    cand_ch.dir_x           <= it.dir_x;
    cand_ch.dir_y           <= it.dir_y;
    cand_ch.same_type_check <= it.same_type_check;
    cand_ch.self_id         <= it.self_id;
    cand_ch.cand_id         <= it.cand_id;
    cand_ch.cand_x          <= it.cand_x;
    cand_ch.cand_y          <= it.cand_y;
    cand_ch.cand_last       <= it.cand_last;
    do @(posedge clk_i); while (cand_ch.ready !== 1'b1);
    items_sent++;
    if (sender_gaps && !calm && $urandom_range(0, 2) == 0) begin
      cand_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // One query of random content. Most queries cluster the candidates around the
  // reference, which makes ties, zero offsets and close side decisions common; some
  // spread them over the whole plane.
  task automatic random_query(input int unsigned len);
    cand_item_t  it;
    int unsigned spread;
    bit          far_field;
    far_field          = ($urandom_range(0, 3) == 0);
    spread             = ($urandom_range(0, 2) == 0) ? 3 : $urandom_range(4, 3000);
    it.ref_x           = coord_t'($urandom);
    it.ref_y           = coord_t'($urandom);
    it.dir_x           = pick_facing();
    it.dir_y           = pick_facing();
    it.same_type_check = 1'($urandom_range(0, 1));
    it.self_id         = inst_id_t'($urandom);
    sender_gaps        = ($urandom_range(0, 3) != 0);
    for (int unsigned k = 0; k < len; k++) begin
      // Now and then the reference moves in the middle of a query.
      if ($urandom_range(0, 19) == 0) begin
        it.ref_x = coord_t'($urandom);
        it.ref_y = coord_t'($urandom);
        it.dir_x = pick_facing();
        it.dir_y = pick_facing();
      end
      it.cand_id = ($urandom_range(0, 5) == 0) ? it.self_id : inst_id_t'($urandom);
      if (far_field || $urandom_range(0, 9) == 0) begin
        it.cand_x = coord_t'($urandom);
        it.cand_y = coord_t'($urandom);
      end else begin
        it.cand_x = nudge(it.ref_x, spread);
        it.cand_y = nudge(it.ref_y, spread);
      end
      it.cand_last = (k + 1 == len);
      offer_candidate(it);
    end
  endtask

  initial begin : stimulus
    int unsigned len;
    cand_ch.valid           <= 1'b0;
    cand_ch.ref_x           <= '0;
    cand_ch.ref_y           <= '0;
    cand_ch.dir_x           <= '0;
    cand_ch.dir_y           <= '0;
    cand_ch.same_type_check <= 1'b0;
    cand_ch.self_id         <= '0;
    cand_ch.cand_id         <= '0;
    cand_ch.cand_x          <= '0;
    cand_ch.cand_y          <= '0;
    cand_ch.cand_last       <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_gaps = 1'b1;
    // The only candidate is the reference itself and is skipped: both sides come back empty.
    offer_candidate(make_item(0, 0, FACING_ONE, 0, 1'b1, 7, 7, 5, 5, 1'b1));
    // A candidate on top of the reference has a zero dot product and lands on the right.
    offer_candidate(make_item(100, -100, 0, FACING_ONE, 1'b0, 1, 2, 100, -100, 1'b1));
    // Corner to corner: the longest possible offsets, both on the left. The closer one
    // has id zero, and the closing item is a skipped self candidate.
    offer_candidate(make_item(-32768, -32768, -FACING_ONE, -FACING_ONE, 1'b0, 0, 65535,
                              32767, 32767, 1'b0));
    offer_candidate(make_item(-32768, -32768, -FACING_ONE, -FACING_ONE, 1'b0, 0, 0,
                              32767, -32768, 1'b0));
    offer_candidate(make_item(-32768, -32768, -FACING_ONE, -FACING_ONE, 1'b1, 65535, 65535,
                              0, 0, 1'b1));
    // Equal distances on each side: the first candidate of a side keeps its place.
    offer_candidate(make_item(0, 0, FACING_ONE, 0, 1'b0, 0, 10, 3, 4, 1'b0));
    offer_candidate(make_item(0, 0, FACING_ONE, 0, 1'b0, 0, 20, 4, 3, 1'b0));
    offer_candidate(make_item(0, 0, FACING_ONE, 0, 1'b0, 0, 30, -3, 4, 1'b0));
    offer_candidate(make_item(0, 0, FACING_ONE, 0, 1'b0, 0, 40, -4, -3, 1'b1));
    // A strictly closer candidate replaces the held one; with the same-type check off a
    // candidate carrying the reference's own id still counts.
    offer_candidate(make_item(10, 10, 0, -FACING_ONE, 1'b0, 5, 5, 10, 30, 1'b0));
    offer_candidate(make_item(10, 10, 0, -FACING_ONE, 1'b0, 5, 6, 10, 20, 1'b0));
    offer_candidate(make_item(10, 10, 0, -FACING_ONE, 1'b0, 5, 5, 10, 0, 1'b1));
    // The reference and facing change from item to item; a zero facing puts every
    // candidate on the right.
    offer_candidate(make_item(0, 0, 0, 0, 1'b0, 9, 1, -7, 0, 1'b0));
    offer_candidate(make_item(1000, 1000, -FACING_ONE, 0, 1'b0, 9, 2, 1003, 1000, 1'b0));
    offer_candidate(make_item(-5, -5, FACING_ONE, -FACING_ONE, 1'b0, 9, 3,
                              32767, -32768, 1'b1));
    // A skipped self candidate in the middle of a query, then a far one on the left.
    offer_candidate(make_item(0, 0, FACING_ONE, 0, 1'b1, 32768, 32768, 1, 0, 1'b0));
    offer_candidate(make_item(0, 0, FACING_ONE, 0, 1'b1, 32768, 32767, -32768, 32767, 1'b1));

    // Random queries. The result side starts with one long hold-off so that the block
    // backs up and stalls its input while candidates keep being offered.
    hold_req = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      calm = (items_sent + CALM_ITEMS >= TOTAL_ITEMS);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      random_query(len);
    end
    cand_ch.valid <= 1'b0;

    // Wait for every owed result, then a little longer to catch anything extra.
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stall bursts mixed with stretches of steady ready,
  // one long hold-off on request, and always ready once the run is calm.
  initial begin : result_side
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            res_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 5)) @(posedge clk_i);
          end
          1: begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clk_i);
          end
          default: begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 5)) @(posedge clk_i);
          end
        endcase
      end
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
